// ===== src/bvhms_pkg.sv =====
`default_nettype none
package bvhms_pkg;

  localparam int unsigned MaxTrianglesDefault = 65536;
  localparam int unsigned CoordBitsDefault    = 32;
  localparam int unsigned NumRegs             = 6;
  localparam int unsigned CfgIdxBits          = 3;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_EXTENT_X = 3'd0,
    REG_EXTENT_Y = 3'd1,
    REG_EXTENT_Z = 3'd2,
    REG_MEAN_X   = 3'd3,
    REG_MEAN_Y   = 3'd4,
    REG_MEAN_Z   = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_SIDE   = 2'd0,
    KIND_BOUNDS = 2'd1,
    KIND_MEAN   = 2'd2
  } row_kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_SIDE,
    ST_BOUNDS0,
    ST_BOUNDS1,
    ST_DIV0,
    ST_MEAN0,
    ST_DIV1,
    ST_MEAN1
  } state_e;

  typedef struct packed {
    logic [15:0]        tri_index;
    logic signed [31:0] v0_x;
    logic signed [31:0] v0_y;
    logic signed [31:0] v0_z;
    logic signed [31:0] v1_x;
    logic signed [31:0] v1_y;
    logic signed [31:0] v1_z;
    logic signed [31:0] v2_x;
    logic signed [31:0] v2_y;
    logic signed [31:0] v2_z;
    logic               final_triangle;
  } tri_in_t;

  typedef struct packed {
    logic [1:0]         row_kind;
    logic               side;
    logic [16:0]        index_or_count;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic               run_end;
  } row_out_t;

  // controller to datapath
  typedef struct packed {
    logic       accum;      // latch input beat
    logic       div_start;
    logic       div_child;
    logic       clear;
    logic       load_row;
    logic [1:0] row_kind;
    logic       row_side;
    logic       row_end;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic fin;
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== src/bvhms_div.sv =====
`default_nettype none
// signed restoring divider, one quotient bit per cycle, truncates toward zero
module bvhms_div import bvhms_pkg::*; #(
  parameter int unsigned NumBits = 50,
  parameter int unsigned DenBits = 27
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic signed [NumBits-1:0] num_i,
  input  wire logic [DenBits-1:0]        den_i,
  output      logic                      busy_o,
  output      logic signed [NumBits-1:0] quot_o
);
  localparam int unsigned CntBits = $clog2(NumBits + 1);

  logic [NumBits-1:0] q_q, q_d;
  logic [DenBits:0]   rem_q, rem_d;
  logic [DenBits-1:0] den_q;
  logic               neg_q;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic [DenBits:0]   trial;
  logic [NumBits-1:0] mag;

  assign mag   = num_i[NumBits-1] ? (~num_i + 1'b1) : num_i;
  assign trial = {rem_q[DenBits-1:0], q_q[NumBits-1]};

  always_comb begin
    q_d   = q_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (cnt_q != '0) begin
      q_d = {q_q[NumBits-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d  = trial - {1'b0, den_q};
        q_d[0] = 1'b1;
      end else begin
        rem_d = trial;
      end
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntBits'(NumBits);
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= mag;
      rem_q <= '0;
      den_q <= den_i;
      neg_q <= num_i[NumBits-1];
    end else begin
      q_q   <= q_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = neg_q ? $signed(~q_q + 1'b1) : $signed(q_q);
endmodule
`default_nettype wire

// ===== src/bvhms_datapath.sv =====
`default_nettype none
module bvhms_datapath import bvhms_pkg::*; #(
  parameter int unsigned MaxTriangles = MaxTrianglesDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tri_in_t           tri_i,
  input  wire logic              cfg_valid_i,
  input  wire logic [CfgIdxBits-1:0] cfg_index_i,
  input  wire logic [31:0]       cfg_data_i,
  input  wire dp_cmd_t           cmd_i,
  output      dp_sts_t           sts_o,
  output      row_out_t          row_o
);
  localparam int unsigned CoordBits = CoordBitsDefault;
  localparam int unsigned SumBits = CoordBits + 18;
  localparam int unsigned CntBits = $clog2(MaxTriangles + 1);
  localparam int unsigned DenBits = CntBits + 2;
  localparam logic signed [CoordBits-1:0] CMax = {1'b0, {(CoordBits-1){1'b1}}};
  localparam logic signed [CoordBits-1:0] CMin = {1'b1, {(CoordBits-1){1'b0}}};
  localparam logic signed [SumBits-1:0] SMax = {1'b0, {(SumBits-1){1'b1}}};
  localparam logic signed [SumBits-1:0] SMin = {1'b1, {(SumBits-1){1'b0}}};

  logic [31:0] ext_q [3];
  logic signed [31:0] mean_q [3];

  logic signed [CoordBits-1:0] v_q [3][3];
  logic [15:0] idx_q;
  logic        fin_q;
  logic signed [CoordBits-1:0] lo_q [2][3];
  logic signed [CoordBits-1:0] hi_q [2][3];
  logic signed [SumBits-1:0]   sum_q [2][3];
  logic [CntBits-1:0]          cnt_q [2];
  logic signed [CoordBits+1:0] vs [3];
  logic [1:0] axis;
  logic       side_d;
  logic signed [CoordBits+1:0] vsel;
  logic signed [33:0] mean3;
  logic signed [SumBits:0] acc [3];
  logic signed [CoordBits-1:0] vmin [3];
  logic signed [CoordBits-1:0] vmax [3];

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        ext_q[i]  <= '0;
        mean_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_EXTENT_X: ext_q[0]  <= cfg_data_i;
        REG_EXTENT_Y: ext_q[1]  <= cfg_data_i;
        REG_EXTENT_Z: ext_q[2]  <= cfg_data_i;
        REG_MEAN_X:   mean_q[0] <= cfg_data_i;
        REG_MEAN_Y:   mean_q[1] <= cfg_data_i;
        REG_MEAN_Z:   mean_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (ext_q[0] >= ext_q[1] && ext_q[0] >= ext_q[2]) axis = 2'd0;
    else if (ext_q[1] >= ext_q[2]) axis = 2'd1;
    else axis = 2'd2;
  end

  // stage 1: input beat registered, vertex sums
  always_ff @(posedge clk_i) begin
    if (cmd_i.accum) begin
      v_q[0][0] <= CoordBits'(tri_i.v0_x);
      v_q[0][1] <= CoordBits'(tri_i.v0_y);
      v_q[0][2] <= CoordBits'(tri_i.v0_z);
      v_q[1][0] <= CoordBits'(tri_i.v1_x);
      v_q[1][1] <= CoordBits'(tri_i.v1_y);
      v_q[1][2] <= CoordBits'(tri_i.v1_z);
      v_q[2][0] <= CoordBits'(tri_i.v2_x);
      v_q[2][1] <= CoordBits'(tri_i.v2_y);
      v_q[2][2] <= CoordBits'(tri_i.v2_z);
      idx_q     <= tri_i.tri_index;
      fin_q     <= tri_i.final_triangle;
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      vs[a] = (CoordBits+2)'(v_q[0][a]) + (CoordBits+2)'(v_q[1][a])
            + (CoordBits+2)'(v_q[2][a]);
    end
    vsel  = vs[axis];
    mean3 = 34'(mean_q[axis]) + 34'(mean_q[axis]) + 34'(mean_q[axis]);
    side_d = ((CoordBits+36)'(vsel) >= (CoordBits+36)'(mean3)) ? 1'b0 : 1'b1;
    for (int a = 0; a < 3; a++) begin
      acc[a] = (SumBits+1)'(sum_q[side_d][a]) + (SumBits+1)'(vs[a]);
    end
    // new child box corners, min and max over the old corner and three vertices
    for (int a = 0; a < 3; a++) begin
      vmin[a] = lo_q[side_d][a];
      vmax[a] = hi_q[side_d][a];
      for (int t = 0; t < 3; t++) begin
        if (v_q[t][a] < vmin[a]) vmin[a] = v_q[t][a];
        if (v_q[t][a] > vmax[a]) vmax[a] = v_q[t][a];
      end
    end
  end

  // child accumulators, updated when the side row is loaded after the beat is latched
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 2; c++) begin
        for (int a = 0; a < 3; a++) begin
          lo_q[c][a]  <= CMax;
          hi_q[c][a]  <= CMin;
          sum_q[c][a] <= '0;
        end
        cnt_q[c] <= '0;
      end
    end else if (cmd_i.clear) begin
      for (int c = 0; c < 2; c++) begin
        for (int a = 0; a < 3; a++) begin
          lo_q[c][a]  <= CMax;
          hi_q[c][a]  <= CMin;
          sum_q[c][a] <= '0;
        end
        cnt_q[c] <= '0;
      end
    end else if (cmd_i.load_row && cmd_i.row_kind == KIND_SIDE) begin
      for (int a = 0; a < 3; a++) begin
        lo_q[side_d][a] <= vmin[a];
        hi_q[side_d][a] <= vmax[a];
        if (acc[a] > (SumBits+1)'(SMax))      sum_q[side_d][a] <= SMax;
        else if (acc[a] < (SumBits+1)'(SMin)) sum_q[side_d][a] <= SMin;
        else sum_q[side_d][a] <= acc[a][SumBits-1:0];
      end
      if (cnt_q[side_d] < CntBits'(MaxTriangles)) cnt_q[side_d] <= cnt_q[side_d] + 1'b1;
    end
  end

  // three dividers, one per axis
  logic [DenBits-1:0] den;
  logic signed [SumBits-1:0] quot [3];
  logic busy [3];
  assign den = DenBits'(cnt_q[cmd_i.div_child]) * DenBits'(3);

  for (genvar a = 0; a < 3; a++) begin : g_div
    bvhms_div #(.NumBits(SumBits), .DenBits(DenBits)) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (cmd_i.div_start),
      .num_i   (sum_q[cmd_i.div_child][a]),
      .den_i   (den),
      .busy_o  (busy[a]),
      .quot_o  (quot[a])
    );
  end

  function automatic logic signed [31:0] clampc(logic signed [SumBits-1:0] v);
    logic signed [CoordBits-1:0] r;
    if (v > SumBits'(CMax))      r = CMax;
    else if (v < SumBits'(CMin)) r = CMin;
    else r = v[CoordBits-1:0];
    return 32'(r);
  endfunction

  row_out_t row_q, row_d;

  always_comb begin
    row_d = row_q;
    if (cmd_i.load_row) begin
      row_d          = '0;
      row_d.row_kind = cmd_i.row_kind;
      row_d.run_end  = cmd_i.row_end;
      row_d.side     = cmd_i.row_side;
      case (row_kind_e'(cmd_i.row_kind))
        KIND_SIDE: begin
          row_d.side           = side_d;
          row_d.index_or_count = 17'(idx_q);
        end
        KIND_BOUNDS: begin
          row_d.a_x = 32'(lo_q[cmd_i.row_side][0]);
          row_d.a_y = 32'(lo_q[cmd_i.row_side][1]);
          row_d.a_z = 32'(lo_q[cmd_i.row_side][2]);
          row_d.b_x = 32'(hi_q[cmd_i.row_side][0]);
          row_d.b_y = 32'(hi_q[cmd_i.row_side][1]);
          row_d.b_z = 32'(hi_q[cmd_i.row_side][2]);
        end
        KIND_MEAN: begin
          row_d.index_or_count = 17'(cnt_q[cmd_i.row_side]);
          if (cnt_q[cmd_i.row_side] != '0) begin
            row_d.a_x = clampc(quot[0]);
            row_d.a_y = clampc(quot[1]);
            row_d.a_z = clampc(quot[2]);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
  end

  assign row_o          = row_q;
  assign sts_o.div_done = !busy[0] && !busy[1] && !busy[2] && !cmd_i.div_start;
  assign sts_o.fin      = fin_q;
endmodule
`default_nettype wire

// ===== src/bvhms_ctrl.sv =====
`default_nettype none
module bvhms_ctrl import bvhms_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output      logic    in_ready_o,
  output      logic    out_valid_o,
  input  wire logic    out_ready_i,
  input  wire dp_sts_t sts_i,
  output      dp_cmd_t cmd_o
);
  state_e state_q, state_d;
  logic   ov_q, ov_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  // a row is loaded only when the output register is free or being drained
  logic free;
  assign free = !ov_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    ov_d       = ov_q && !out_ready_i;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accum = 1'b1;
          state_d     = ST_SIDE;
        end
      end
      ST_SIDE: if (free) begin
        cmd_o.load_row = 1'b1;
        cmd_o.row_kind = KIND_SIDE;
        cmd_o.row_end  = !sts_i.fin;
        ov_d           = 1'b1;
        state_d        = sts_i.fin ? ST_BOUNDS0 : ST_IDLE;
      end
      ST_BOUNDS0: if (free) begin
        cmd_o.load_row = 1'b1;
        cmd_o.row_kind = KIND_BOUNDS;
        ov_d           = 1'b1;
        cmd_o.div_start = 1'b1;
        state_d        = ST_BOUNDS1;
      end
      ST_BOUNDS1: if (free) begin
        cmd_o.load_row = 1'b1;
        cmd_o.row_kind = KIND_BOUNDS;
        cmd_o.row_side = 1'b1;
        ov_d           = 1'b1;
        state_d        = ST_DIV0;
      end
      ST_DIV0: if (sts_i.div_done) state_d = ST_MEAN0;
      ST_MEAN0: if (free) begin
        cmd_o.load_row  = 1'b1;
        cmd_o.row_kind  = KIND_MEAN;
        ov_d            = 1'b1;
        cmd_o.div_start = 1'b1;
        cmd_o.div_child = 1'b1;
        state_d         = ST_DIV1;
      end
      ST_DIV1: begin
        cmd_o.div_child = 1'b1;
        if (sts_i.div_done) state_d = ST_MEAN1;
      end
      ST_MEAN1: if (free) begin
        cmd_o.load_row = 1'b1;
        cmd_o.row_kind = KIND_MEAN;
        cmd_o.row_side = 1'b1;
        cmd_o.row_end  = 1'b1;
        cmd_o.div_child = 1'b1;
        ov_d           = 1'b1;
        state_d        = ST_ACCUM;
      end
      ST_ACCUM: begin
        cmd_o.clear = 1'b1;
        state_d     = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = ov_q;
endmodule
`default_nettype wire

// ===== src/bvh_mean_split_partition_top.sv =====
`default_nettype none
// Mean-split partition of one BVH node. Write the node extents and mean
// centroid, then stream the node's triangles; each gives one side row, and
// the triangle flagged final adds child bounds and mean/count rows for both
// children. Each triangle is latched, then the side decision and child
// update follow once the output register is free. After the final
// triangle the bit-serial mean dividers run once per child.
module bvh_mean_split_partition_top import bvhms_pkg::*; #(
  parameter int unsigned MaxTriangles = MaxTrianglesDefault
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire tri_in_t               in_data_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      row_out_t              out_data_o,
  input  wire logic                  cfg_valid_i,
  output      logic                  cfg_ready_o,
  input  wire logic [CfgIdxBits-1:0] cfg_index_i,
  input  wire logic [31:0]           cfg_data_i
);
  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  bvhms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bvhms_datapath #(.MaxTriangles(MaxTriangles)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tri_i       (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .row_o       (out_data_o)
  );
endmodule
`default_nettype wire

// ===== src/bvhms_checker.sv =====
`default_nettype none
module bvhms_props import bvhms_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_ready_i,
  input wire logic     out_valid_i,
  input wire logic     out_ready_i,
  input wire row_out_t out_data_i
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("output beat dropped or changed while stalled");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_data_i.row_kind == KIND_SIDE ||
                     out_data_i.row_kind == KIND_BOUNDS ||
                     out_data_i.row_kind == KIND_MEAN))
    else $error("illegal row kind");

  a_side_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.row_kind == KIND_SIDE |->
      out_data_i.a_x == '0 && out_data_i.b_z == '0)
    else $error("side row carries coordinates");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second beat taken before the first was handled");
endmodule

bind bvh_mean_split_partition_top bvhms_props u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);
`default_nettype wire
